// ===== design/sfr_pkg.sv =====
// Package for the sum-checked frame receiver: constants, codes and shared types.
// Used by the channel interfaces and by every module of the receiver.
package sfr_pkg;

  localparam int MAX_PAYLOAD = 32;
  localparam int IDX_W = $clog2(MAX_PAYLOAD);
  localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int REG_IDX_W = 1;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_SUMERR = 2'd2;
  localparam logic [1:0] KIND_LENERR = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_HEADER = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_LEN = 1'b1;

  localparam logic [7:0] HEADER_RESET = 8'd170;
  localparam logic [5:0] MAX_LEN_RESET = 6'd32;
  localparam logic [15:0] ERR_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    F_IDLE,
    F_WANT_CMD,
    F_WANT_LEN,
    F_DATA,
    F_CHECK
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_EMIT
  } back_state_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       command;
    logic [7:0]       frame_length;
    logic [CNT_W-1:0] count;
    logic [15:0]      errors;
  } job_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } mem_wr_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic drain_done;
  } back_status_t;

endpackage

// ===== design/sfr_channels.sv =====
// Channel interfaces of the frame receiver: received bytes, results and register writes.
// Depends on sfr_pkg for field widths.
interface sfr_in_if;
  import sfr_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfr_out_if;
  import sfr_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic [7:0]       command;
  logic [7:0]       frame_length;
  logic [IDX_W-1:0] byte_index;
  logic [7:0]       payload_byte;
  logic             last;
  logic [15:0]      errors_seen;
  modport source (output valid, output kind, output command, output frame_length,
                  output byte_index, output payload_byte, output last,
                  output errors_seen, input ready);
  modport sink (input valid, input kind, input command, input frame_length,
                input byte_index, input payload_byte, input last,
                input errors_seen, output ready);
endinterface

interface sfr_cfg_if;
  import sfr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [REG_IDX_W-1:0] index;
  logic [7:0]           data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/sum_checked_frame_receiver.sv =====
// Top level of the sum-checked frame receiver: parser front end, job queue, result back end.
// Depends on sfr_pkg, sfr_channels, sfr_front, sfr_queue and sfr_back.
//
// The receiver takes one byte per clock in every frame phase while the job queue has room
// and, in the payload phase, no earlier frame still drains. Header, command, length and
// payload bytes cause no result; the length byte of an oversized frame and the checksum byte
// cause one job in a two-entry queue. Error and empty-frame jobs give one result each. A good
// frame of N payload bytes gives N results, one for each payload byte, each read from the
// registered read port of the 32-entry payload buffer in a read state and sent in an emit
// state, which waits while the result output is stalled. While that buffer still drains,
// payload bytes of the next frame wait at the input; header, command and length bytes are
// still taken unless the queue is full. Register writes take effect at once and the block
// needs no start-up sweep after reset.
module sum_checked_frame_receiver (
  input  logic clk,
  input  logic rst,
  sfr_in_if.sink    rx,
  sfr_out_if.source res,
  sfr_cfg_if.sink   cfg
);
  import sfr_pkg::*;

  logic          push;
  logic          pop;
  job_t          push_job;
  job_t          head;
  mem_wr_t       mem_wr;
  queue_status_t q_status;
  back_status_t  b_status;

  sfr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .rx       (rx),
    .cfg      (cfg),
    .q_status (q_status),
    .b_status (b_status),
    .push     (push),
    .push_job (push_job),
    .mem_wr   (mem_wr)
  );

  sfr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  sfr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .mem_wr   (mem_wr),
    .q_status (q_status),
    .head     (head),
    .pop      (pop),
    .res      (res),
    .b_status (b_status)
  );

endmodule

// ===== design/sfr_front.sv =====
// Front end of the frame receiver: byte parser, checksum, length check and error count.
// Depends on sfr_pkg and the channel interfaces; feeds sfr_queue and the payload buffer.
module sfr_front (
  input  logic                  clk,
  input  logic                  rst,
  sfr_in_if.sink                rx,
  sfr_cfg_if.sink               cfg,
  input  sfr_pkg::queue_status_t q_status,
  input  sfr_pkg::back_status_t  b_status,
  output logic                  push,
  output sfr_pkg::job_t         push_job,
  output sfr_pkg::mem_wr_t      mem_wr
);
  import sfr_pkg::*;

  front_state_t     phase;
  front_state_t     phase_next;
  logic [7:0]       header_byte;
  logic [5:0]       max_length;
  logic [7:0]       held_command;
  logic [CNT_W-1:0] held_length;
  logic [CNT_W-1:0] bytes_stored;
  logic [7:0]       running_sum;
  logic [15:0]      error_total;
  logic             drain_pending;

  logic             accept;
  logic [7:0]       b;
  logic [7:0]       sum_add;
  logic [5:0]       limit;
  logic             len_bad;
  logic [15:0]      err_inc;
  logic [CNT_W-1:0] stored_inc;

  assign b = rx.rx_byte;
  assign rx.ready = !q_status.full && !(phase == F_DATA && drain_pending);
  assign accept = rx.valid && rx.ready;
  assign cfg.ready = 1'b1;
  assign sum_add = running_sum + b;
  assign limit = (max_length < 6'(MAX_PAYLOAD)) ? max_length : 6'(MAX_PAYLOAD);
  assign len_bad = b > 8'(limit);
  assign err_inc = error_total + 16'(error_total != ERR_MAX);
  assign stored_inc = bytes_stored + 1'b1;

  always_comb begin
    phase_next = phase;
    case (phase)
      F_IDLE: begin
        if (accept && b == header_byte) phase_next = F_WANT_CMD;
      end
      F_WANT_CMD: begin
        if (accept) phase_next = F_WANT_LEN;
      end
      F_WANT_LEN: begin
        if (accept) begin
          if (len_bad) phase_next = F_IDLE;
          else if (b == 8'd0) phase_next = F_CHECK;
          else phase_next = F_DATA;
        end
      end
      F_DATA: begin
        if (accept && stored_inc >= held_length) phase_next = F_CHECK;
      end
      F_CHECK: begin
        if (accept) phase_next = F_IDLE;
      end
      default: phase_next = F_IDLE;
    endcase
  end

  always_comb begin
    push = 1'b0;
    push_job = '0;
    push_job.command = held_command;
    push_job.errors = error_total;
    mem_wr.en = accept && phase == F_DATA;
    mem_wr.addr = bytes_stored[IDX_W-1:0];
    mem_wr.data = b;
    case (phase)
      F_WANT_LEN: begin
        push = accept && len_bad;
        push_job.kind = KIND_LENERR;
        push_job.frame_length = b;
        push_job.errors = err_inc;
      end
      F_CHECK: begin
        push = accept;
        if (b != running_sum) begin
          push_job.kind = KIND_SUMERR;
          push_job.frame_length = 8'(held_length);
          push_job.errors = err_inc;
        end else if (held_length == '0) begin
          push_job.kind = KIND_EMPTY;
        end else begin
          push_job.kind = KIND_PAYLOAD;
          push_job.frame_length = 8'(held_length);
          push_job.count = held_length;
        end
      end
      default: push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= F_IDLE;
      header_byte <= HEADER_RESET;
      max_length <= MAX_LEN_RESET;
      held_command <= '0;
      held_length <= '0;
      bytes_stored <= '0;
      running_sum <= '0;
      error_total <= '0;
      drain_pending <= 1'b0;
    end else begin
      phase <= phase_next;
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_HEADER: header_byte <= cfg.data;
          REG_MAX_LEN: max_length <= cfg.data[5:0];
          default: header_byte <= header_byte;
        endcase
      end
      if (accept) begin
        case (phase)
          F_IDLE: running_sum <= b;
          F_WANT_CMD: begin
            held_command <= b;
            running_sum <= sum_add;
          end
          F_WANT_LEN: begin
            running_sum <= sum_add;
            if (!len_bad) begin
              held_length <= CNT_W'(b);
              bytes_stored <= '0;
            end
          end
          F_DATA: begin
            running_sum <= sum_add;
            bytes_stored <= stored_inc;
          end
          default: running_sum <= running_sum;
        endcase
      end
      if (push) error_total <= push_job.errors;
      if (push && push_job.kind == KIND_PAYLOAD) drain_pending <= 1'b1;
      else if (b_status.drain_done) drain_pending <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_status.full)
    else $error("Job pushed into a full queue.");
  a_no_overwrite_drain: assert property (@(posedge clk) disable iff (rst)
    mem_wr.en |-> !drain_pending)
    else $error("Payload buffer written while the previous frame drains.");
  a_errors_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> error_total >= $past(error_total))
    else $error("Error count decreased.");
  a_one_payload_job: assert property (@(posedge clk) disable iff (rst)
    (push && push_job.kind == KIND_PAYLOAD) |-> !drain_pending)
    else $error("Second payload job pushed before the first one drained.");
`endif

endmodule

// ===== design/sfr_queue.sv =====
// Two-entry job queue between the parser front end and the result back end.
// Depends on sfr_pkg for the job type.
module sfr_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  sfr_pkg::job_t          push_job,
  input  logic                   pop,
  output sfr_pkg::job_t          head,
  output sfr_pkg::queue_status_t status
);
  import sfr_pkg::*;

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign head = slots[rd_ptr];
  assign status.full = fill == QCNT_W'(QUEUE_DEPTH);
  assign status.empty = fill == '0;

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      fill <= fill + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

// ===== design/sfr_back.sv =====
// Back end of the frame receiver: payload buffer and result sequencer with output register.
// Depends on sfr_pkg and the channel interfaces; takes jobs from sfr_queue.
module sfr_back (
  input  logic                   clk,
  input  logic                   rst,
  input  sfr_pkg::mem_wr_t       mem_wr,
  input  sfr_pkg::queue_status_t q_status,
  input  sfr_pkg::job_t          head,
  output logic                   pop,
  sfr_out_if.source              res,
  output sfr_pkg::back_status_t  b_status
);
  import sfr_pkg::*;

  back_state_t      state;
  back_state_t      state_next;
  logic [7:0]       mem [MAX_PAYLOAD];
  logic [7:0]       rd_data;
  job_t             job;
  logic [IDX_W-1:0] idx;

  logic             out_valid;
  logic [1:0]       out_kind;
  logic [7:0]       out_command;
  logic [7:0]       out_frame_length;
  logic [IDX_W-1:0] out_byte_index;
  logic [7:0]       out_payload_byte;
  logic             out_last;
  logic [15:0]      out_errors;

  logic             slot_free;
  logic             last_entry;
  logic             load_direct;
  logic             load_payload;

  assign slot_free = !out_valid || res.ready;
  assign last_entry = (CNT_W'(idx) + 1'b1) == job.count;

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!q_status.empty && head.kind == KIND_PAYLOAD) state_next = B_READ;
      end
      B_READ: state_next = B_EMIT;
      B_EMIT: begin
        if (slot_free) state_next = last_entry ? B_IDLE : B_READ;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop = 1'b0;
    load_payload = 1'b0;
    case (state)
      B_IDLE: pop = !q_status.empty && (head.kind == KIND_PAYLOAD || slot_free);
      B_EMIT: load_payload = slot_free;
      default: pop = 1'b0;
    endcase
    load_direct = pop && head.kind != KIND_PAYLOAD;
    b_status.drain_done = load_payload && last_entry;
  end

  always_ff @(posedge clk) begin
    if (mem_wr.en) mem[mem_wr.addr] <= mem_wr.data;
    rd_data <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (pop) job <= head;
    if (load_direct) begin
      out_kind <= head.kind;
      out_command <= head.command;
      out_frame_length <= head.frame_length;
      out_byte_index <= '0;
      out_payload_byte <= '0;
      out_last <= 1'b1;
      out_errors <= head.errors;
    end else if (load_payload) begin
      out_kind <= KIND_PAYLOAD;
      out_command <= job.command;
      out_frame_length <= job.frame_length;
      out_byte_index <= idx;
      out_payload_byte <= rd_data;
      out_last <= last_entry;
      out_errors <= job.errors;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      idx <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (pop) idx <= '0;
      else if (load_payload && !last_entry) idx <= idx + 1'b1;
      if (load_direct || load_payload) out_valid <= 1'b1;
      else if (res.ready) out_valid <= 1'b0;
    end
  end

  assign res.valid = out_valid;
  assign res.kind = out_kind;
  assign res.command = out_command;
  assign res.frame_length = out_frame_length;
  assign res.byte_index = out_byte_index;
  assign res.payload_byte = out_payload_byte;
  assign res.last = out_last;
  assign res.errors_seen = out_errors;

`ifndef NO_ASSERTIONS
  a_no_load_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res.ready) |-> !(load_direct || load_payload))
    else $error("Result register overwritten while stalled.");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("Job taken from an empty queue.");
  a_read_then_emit: assert property (@(posedge clk) disable iff (rst)
    state == B_READ |=> state == B_EMIT)
    else $error("Payload read not followed by emit.");
`endif

endmodule
